// ===== sv/sba_pkg.sv =====
// Shared constants and types for the spectrum bin averager.
package sba_pkg;

    localparam int MAX_BINS = 1024;
    localparam int IDX_W    = $clog2(MAX_BINS);
    localparam int PWR_W    = 17;
    localparam int FREQ_W   = 33;
    localparam int RATE_W   = 27;
    localparam int ALPHA_W  = 16;
    localparam int COUNT_W  = 11;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int SEL_W    = ADDR_W - 2;
    localparam int ENTRY_W  = 3 * PWR_W;
    localparam int DIFF_W   = PWR_W + 1;
    localparam int PROD_W   = ALPHA_W + 1 + DIFF_W;

    localparam logic [SEL_W-1:0] REG_EMA_ALPHA   = SEL_W'(0);
    localparam logic [SEL_W-1:0] REG_BIN_COUNT   = SEL_W'(1);
    localparam logic [SEL_W-1:0] REG_FLOOR_LEVEL = SEL_W'(2);

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd8520;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

    typedef logic signed [PWR_W-1:0] t_pwr;

    localparam t_pwr FLOOR_RESET = -17'sd33280;

    typedef struct packed {
        logic [ALPHA_W-1:0] alpha;
        logic [IDX_W-1:0]   last_idx;
        t_pwr               floor_lvl;
        logic               clear_all;
    } t_cfg;

    typedef struct packed {
        t_pwr avg;
        t_pwr peak;
        t_pwr low;
    } t_entry;

endpackage

// ===== sv/sba_if.sv =====
// Stream channel interfaces for bins in and results out.
interface sba_in_if import sba_pkg::*; ();
    logic              valid;
    logic              ready;
    t_pwr              power;
    logic [FREQ_W-1:0] center_freq;
    logic [RATE_W-1:0] sample_rate;

    modport source (output valid, power, center_freq, sample_rate, input ready);
    modport sink (input valid, power, center_freq, sample_rate, output ready);
endinterface

interface sba_out_if import sba_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] bin_index;
    t_pwr             average;
    t_pwr             peak_hold;
    t_pwr             low_hold;
    t_pwr             row_avg_min;
    t_pwr             row_avg_max;
    logic             last_of_row;

    modport source (output valid, bin_index, average, peak_hold, low_hold, row_avg_min,
                    row_avg_max, last_of_row, input ready);
    modport sink (input valid, bin_index, average, peak_hold, low_hold, row_avg_min,
                  row_avg_max, last_of_row, output ready);
endinterface

// ===== sv/sba_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module sba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/sba_regs.sv =====
// APB configuration registers: averaging weight, bin count and floor level.
module sba_regs import sba_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [ALPHA_W-1:0] r_ema_alpha;
    logic [COUNT_W-1:0] r_bin_count;
    t_pwr               r_floor_level;
    logic               wr_en;
    logic [SEL_W-1:0]   reg_sel;
    logic [IDX_W-1:0]   last_idx;

    assign reg_sel = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ema_alpha   <= ALPHA_RESET;
            r_bin_count   <= COUNT_RESET;
            r_floor_level <= FLOOR_RESET;
        end else if (wr_en) begin
            case (reg_sel)
                REG_EMA_ALPHA: begin
                    r_ema_alpha <= pwdata[ALPHA_W-1:0];
                end
                REG_BIN_COUNT: begin
                    r_bin_count <= pwdata[COUNT_W-1:0];
                end
                REG_FLOOR_LEVEL: begin
                    r_floor_level <= t_pwr'(pwdata[PWR_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    // zero counts as one bin, oversize counts clamp to the store depth
    always_comb begin
        if (r_bin_count == '0) begin
            last_idx = '0;
        end else if (32'(r_bin_count) > 32'(MAX_BINS)) begin
            last_idx = IDX_W'(MAX_BINS - 1);
        end else begin
            last_idx = IDX_W'(r_bin_count - 1'b1);
        end
    end

    always_comb begin
        case (reg_sel)
            REG_EMA_ALPHA:   prdata = DATA_W'(r_ema_alpha);
            REG_BIN_COUNT:   prdata = DATA_W'(r_bin_count);
            REG_FLOOR_LEVEL: prdata = DATA_W'(r_floor_level);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg.alpha     = r_ema_alpha;
    assign o_cfg.last_idx  = last_idx;
    assign o_cfg.floor_lvl = r_floor_level;
    assign o_cfg.clear_all = wr_en && (reg_sel == REG_BIN_COUNT);

endmodule

// ===== sv/spectrum_bin_averager_top.sv =====
// Spectrum bin averager: per-bin moving average with peak and low hold.
//
//  Channel   Dir  Handshake            Carries
//  i_bin     in   valid/ready          power, center_freq, sample_rate
//  o_res     out  valid/ready          bin_index, average, holds, row min/max, last_of_row
//  APB       in   psel/penable/pready  ema_alpha @0x0, bin_count @0x4, floor_level @0x8
//
// One item per clock unless the output stalls or a read-stage hazard holds it off.
// With a one-bin row every item reuses the entry still in the read stage, so each item
// waits until the one before leaves it; the RAM read-modify-write loop sets this.
// On reset the stores are cleared logically by the first-row and hold flags.
// A stalled output holds the result; items are still taken until the pipeline fills.
module spectrum_bin_averager_top import sba_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sba_in_if.sink            i_bin,
    sba_out_if.source         o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg cfg;

    // front end state
    logic [IDX_W-1:0]  r_pos;
    logic              r_first_row;
    logic              r_hold_full;
    t_pwr              r_hold_floor;
    logic [FREQ_W-1:0] r_last_center;
    logic [RATE_W-1:0] r_last_rate;

    logic en;
    logic hazard;
    logic accept;
    logic tune_chg;
    logic is_last;
    logic hold_clr;

    // read stage
    logic             r_s1_valid;
    logic [IDX_W-1:0] r_s1_pos;
    t_pwr             r_s1_x;
    logic             r_s1_first;
    logic             r_s1_hclr;
    logic             r_s1_last;

    logic [ENTRY_W-1:0]       ram_rdata;
    t_entry                   old;
    t_pwr                     old_peak;
    t_pwr                     old_low;
    t_pwr                     s1_peak;
    t_pwr                     s1_low;
    logic signed [DIFF_W-1:0] s1_diff;

    // multiply stage
    logic                     r_s2_valid;
    logic [IDX_W-1:0]         r_s2_pos;
    t_pwr                     r_s2_x;
    logic                     r_s2_first;
    logic                     r_s2_last;
    t_pwr                     r_s2_prev;
    logic signed [DIFF_W-1:0] r_s2_diff;
    t_pwr                     r_s2_peak;
    t_pwr                     r_s2_low;
    logic signed [PROD_W-1:0] s2_prod;

    // write-back stage
    logic                     r_s3_valid;
    logic [IDX_W-1:0]         r_s3_pos;
    t_pwr                     r_s3_x;
    logic                     r_s3_first;
    logic                     r_s3_last;
    t_pwr                     r_s3_prev;
    logic signed [PROD_W-1:0] r_s3_prod;
    t_pwr                     r_s3_peak;
    t_pwr                     r_s3_low;
    logic signed [DIFF_W-1:0] s3_sum;
    t_pwr                     s3_avg;
    t_entry                   s3_entry;
    logic                     we;

    logic             r_wb_valid;
    logic [IDX_W-1:0] r_wb_pos;
    t_entry           r_wb_data;

    t_pwr r_run_min;
    t_pwr r_run_max;
    t_pwr n_run_min;
    t_pwr n_run_max;

    // output register
    logic             r_out_valid;
    logic [IDX_W-1:0] r_out_idx;
    t_pwr             r_out_avg;
    t_pwr             r_out_peak;
    t_pwr             r_out_low;
    t_pwr             r_out_min;
    t_pwr             r_out_max;
    logic             r_out_last;

    sba_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // advance the pipeline unless a finished item would overwrite a waiting result
    assign en       = !r_out_valid || o_res.ready || !r_s3_valid;
    // hold off while the same entry is still in the read stage (one-bin rows)
    assign hazard   = r_s1_valid && (r_s1_pos == r_pos);
    assign i_bin.ready = en && !hazard;
    assign accept   = i_bin.valid && i_bin.ready;

    assign tune_chg = (r_pos == '0) && ((i_bin.center_freq != r_last_center) ||
                                        (i_bin.sample_rate != r_last_rate));
    assign is_last  = (r_pos == cfg.last_idx);
    assign hold_clr = tune_chg || !r_hold_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_first_row   <= 1'b1;
            r_hold_full   <= 1'b0;
            r_hold_floor  <= FLOOR_RESET;
            r_last_center <= '0;
            r_last_rate   <= '0;
        end else if (cfg.clear_all) begin
            r_pos        <= '0;
            r_first_row  <= 1'b1;
            r_hold_full  <= 1'b0;
            r_hold_floor <= cfg.floor_lvl;
        end else if (accept) begin
            if (tune_chg) begin
                r_last_center <= i_bin.center_freq;
                r_last_rate   <= i_bin.sample_rate;
                r_hold_floor  <= cfg.floor_lvl;
            end
            if (is_last) begin
                r_pos       <= '0;
                r_first_row <= 1'b0;
                r_hold_full <= 1'b1;
            end else begin
                r_pos <= r_pos + 1'b1;
                if (tune_chg) begin
                    r_hold_full <= 1'b0;
                end
            end
        end
    end

    sba_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BINS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_s3_pos),
        .i_wdata (s3_entry),
        .i_re    (accept),
        .i_raddr (r_pos),
        .o_rdata (ram_rdata)
    );

    // forward the newest copy of the entry: write-back stage, then last write, then RAM
    always_comb begin
        old = t_entry'(ram_rdata);
        if (r_wb_valid && (r_wb_pos == r_s1_pos)) begin
            old = r_wb_data;
        end
        if (r_s3_valid && (r_s3_pos == r_s1_pos)) begin
            old = s3_entry;
        end
        old_peak = r_s1_hclr ? r_hold_floor : old.peak;
        old_low  = r_s1_hclr ? t_pwr'(0) : old.low;
        s1_peak  = (r_s1_x > old_peak) ? r_s1_x : old_peak;
        s1_low   = (r_s1_x < old_low) ? r_s1_x : old_low;
        s1_diff  = DIFF_W'(r_s1_x) - DIFF_W'(old.avg);
    end

    assign s2_prod = $signed({1'b0, cfg.alpha}) * r_s2_diff;

    always_comb begin
        s3_sum         = DIFF_W'(r_s3_prev) + r_s3_prod[ALPHA_W +: DIFF_W];
        s3_avg         = r_s3_first ? r_s3_x : s3_sum[PWR_W-1:0];
        s3_entry.avg   = s3_avg;
        s3_entry.peak  = r_s3_peak;
        s3_entry.low   = r_s3_low;
    end

    assign we = en && r_s3_valid;

    // row bounds restart at bin zero
    always_comb begin
        if (r_s3_pos == '0) begin
            n_run_min = s3_avg;
            n_run_max = s3_avg;
        end else begin
            n_run_min = (s3_avg < r_run_min) ? s3_avg : r_run_min;
            n_run_max = (s3_avg > r_run_max) ? s3_avg : r_run_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_pos   <= r_pos;
            r_s1_x     <= i_bin.power;
            r_s1_first <= r_first_row;
            r_s1_hclr  <= hold_clr;
            r_s1_last  <= is_last;

            r_s2_pos   <= r_s1_pos;
            r_s2_x     <= r_s1_x;
            r_s2_first <= r_s1_first;
            r_s2_last  <= r_s1_last;
            r_s2_prev  <= old.avg;
            r_s2_diff  <= s1_diff;
            r_s2_peak  <= s1_peak;
            r_s2_low   <= s1_low;

            r_s3_pos   <= r_s2_pos;
            r_s3_x     <= r_s2_x;
            r_s3_first <= r_s2_first;
            r_s3_last  <= r_s2_last;
            r_s3_prev  <= r_s2_prev;
            r_s3_prod  <= s2_prod;
            r_s3_peak  <= r_s2_peak;
            r_s3_low   <= r_s2_low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_valid <= 1'b0;
            r_run_min  <= '0;
            r_run_max  <= '0;
        end else if (we) begin
            r_wb_valid <= 1'b1;
            r_run_min  <= n_run_min;
            r_run_max  <= n_run_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_wb_pos  <= r_s3_pos;
            r_wb_data <= s3_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (we) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_out_idx  <= r_s3_pos;
            r_out_avg  <= s3_avg;
            r_out_peak <= r_s3_peak;
            r_out_low  <= r_s3_low;
            r_out_min  <= n_run_min;
            r_out_max  <= n_run_max;
            r_out_last <= r_s3_last;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.bin_index   = r_out_idx;
    assign o_res.average     = r_out_avg;
    assign o_res.peak_hold   = r_out_peak;
    assign o_res.low_hold    = r_out_low;
    assign o_res.row_avg_min = r_out_min;
    assign o_res.row_avg_max = r_out_max;
    assign o_res.last_of_row = r_out_last;

    a_row_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.row_avg_min <= o_res.average) &&
                        (o_res.average <= o_res.row_avg_max))
        else $error("row bounds do not enclose the bin average");

    a_low_nonpos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.low_hold <= t_pwr'(0)))
        else $error("low hold above its zero start value");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= cfg.last_idx)
        else $error("bin position beyond the active row length");

    a_first_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_first_row |-> !r_hold_full)
        else $error("holds marked filled during the first row");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s2_valid) |-> (r_s1_pos != r_s2_pos))
        else $error("same entry in read and multiply stages");

endmodule
